// ----- design/mexp_pkg.sv -----
// shared constants, types and controller state encoding for the modular exponentiation block
`default_nettype none
package mexp_pkg;

   localparam int WORD_BITS     = 32;
   localparam int FIELD_BITS    = 32;
   localparam int DVD_BITS      = 2 * WORD_BITS;
   localparam int STEP_COUNT    = DVD_BITS / 2;
   localparam int CNT_BITS      = $clog2(STEP_COUNT);
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CSR_ADDR_BITS-1:0] REG_MODULUS_ADDR = CSR_ADDR_BITS'(0);
   localparam logic [WORD_BITS-1:0]     MODULUS_RESET    = WORD_BITS'(2);
   localparam logic [WORD_BITS-1:0]     MODULUS_MIN      = WORD_BITS'(2);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_SCAN_RED,
      ST_SCAN_WB,
      ST_LOOP,
      ST_LOOP_SQ_RED,
      ST_LOOP_SQ_WB,
      ST_LOOP_PM,
      ST_LOOP_PM_RED,
      ST_LOOP_PM_WB,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic mul_start;
      logic mul_sel_prod;
      logic rem_step;
      logic wb_base;
      logic wb_prod;
      logic seed;
      logic set_one;
      logic shift;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic exp_zero;
      logic exp_lsb;
      logic rem_done;
   } dp_status_type;

endpackage
`default_nettype wire

// ----- design/mexp_ctrl.sv -----
// square and multiply sequencer driving the exponentiation datapath
`default_nettype none
module mexp_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire mexp_pkg::dp_status_type status,
   output mexp_pkg::dp_cmd_type        cmd
);

   mexp_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == mexp_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mexp_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = mexp_pkg::ST_CHECK;
         end
         mexp_pkg::ST_CHECK: begin
            state_in = status.exp_zero ? mexp_pkg::ST_DONE : mexp_pkg::ST_SCAN;
         end
         mexp_pkg::ST_SCAN: begin
            state_in = status.exp_lsb ? mexp_pkg::ST_LOOP : mexp_pkg::ST_SCAN_RED;
         end
         mexp_pkg::ST_SCAN_RED: begin
            if (status.rem_done) state_in = mexp_pkg::ST_SCAN_WB;
         end
         mexp_pkg::ST_SCAN_WB: begin
            state_in = mexp_pkg::ST_SCAN;
         end
         mexp_pkg::ST_LOOP: begin
            state_in = status.exp_zero ? mexp_pkg::ST_DONE : mexp_pkg::ST_LOOP_SQ_RED;
         end
         mexp_pkg::ST_LOOP_SQ_RED: begin
            if (status.rem_done) state_in = mexp_pkg::ST_LOOP_SQ_WB;
         end
         mexp_pkg::ST_LOOP_SQ_WB: begin
            state_in = status.exp_lsb ? mexp_pkg::ST_LOOP_PM : mexp_pkg::ST_LOOP;
         end
         mexp_pkg::ST_LOOP_PM: begin
            state_in = mexp_pkg::ST_LOOP_PM_RED;
         end
         mexp_pkg::ST_LOOP_PM_RED: begin
            if (status.rem_done) state_in = mexp_pkg::ST_LOOP_PM_WB;
         end
         mexp_pkg::ST_LOOP_PM_WB: begin
            state_in = mexp_pkg::ST_LOOP;
         end
         mexp_pkg::ST_DONE: begin
            if (out_free) state_in = mexp_pkg::ST_IDLE;
         end
         default: begin
            state_in = mexp_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         mexp_pkg::ST_IDLE: begin
            cmd.load = req_tvalid;
         end
         mexp_pkg::ST_CHECK: begin
            cmd.set_one = status.exp_zero;
         end
         mexp_pkg::ST_SCAN: begin
            cmd.seed      = status.exp_lsb;
            cmd.shift     = status.exp_lsb;
            cmd.mul_start = !status.exp_lsb;
         end
         mexp_pkg::ST_SCAN_RED, mexp_pkg::ST_LOOP_SQ_RED, mexp_pkg::ST_LOOP_PM_RED: begin
            cmd.rem_step = 1'b1;
         end
         mexp_pkg::ST_SCAN_WB: begin
            cmd.wb_base = 1'b1;
            cmd.shift   = 1'b1;
         end
         mexp_pkg::ST_LOOP: begin
            cmd.mul_start = !status.exp_zero;
         end
         mexp_pkg::ST_LOOP_SQ_WB: begin
            cmd.wb_base = 1'b1;
            cmd.shift   = !status.exp_lsb;
         end
         mexp_pkg::ST_LOOP_PM: begin
            cmd.mul_start    = 1'b1;
            cmd.mul_sel_prod = 1'b1;
         end
         mexp_pkg::ST_LOOP_PM_WB: begin
            cmd.wb_prod = 1'b1;
            cmd.shift   = 1'b1;
         end
         mexp_pkg::ST_DONE: begin
            cmd.out_load = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mexp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/mexp_dpath.sv -----
// operand registers, multiplier and two-bit-per-cycle remainder unit
`default_nettype none
module mexp_dpath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire mexp_pkg::dp_cmd_type            cmd,
   output mexp_pkg::dp_status_type              status,
   input  wire logic [mexp_pkg::WORD_BITS-1:0]  req_base,
   input  wire logic [mexp_pkg::WORD_BITS-1:0]  req_exponent,
   input  wire logic [mexp_pkg::WORD_BITS-1:0]  modulus,
   output logic      [mexp_pkg::WORD_BITS-1:0]  power_result
);

   localparam int WB = mexp_pkg::WORD_BITS;
   localparam int DB = mexp_pkg::DVD_BITS;
   localparam int CB = mexp_pkg::CNT_BITS;

   logic [WB-1:0] base_ff, base_in;
   logic [WB-1:0] exp_ff, exp_in;
   logic [WB-1:0] prod_ff, prod_in;
   logic [WB-1:0] rem_ff, rem_in;
   logic [WB-1:0] out_ff, out_in;
   logic [DB-1:0] dvd_ff, dvd_in;
   logic [CB-1:0] cnt_ff, cnt_in;

   logic [WB-1:0] mul_a;
   logic [WB:0]   mod_ext;
   logic [WB:0]   trial1, trial2;
   logic [WB-1:0] rem1, rem2;

   assign mul_a   = cmd.mul_sel_prod ? prod_ff : base_ff;
   assign mod_ext = {1'b0, modulus};

   always_comb begin
      trial1 = {rem_ff, dvd_ff[DB-1]};
      rem1   = (trial1 >= mod_ext) ? WB'(trial1 - mod_ext) : trial1[WB-1:0];
      trial2 = {rem1, dvd_ff[DB-2]};
      rem2   = (trial2 >= mod_ext) ? WB'(trial2 - mod_ext) : trial2[WB-1:0];
   end

   always_comb begin
      base_in = base_ff;
      exp_in  = exp_ff;
      prod_in = prod_ff;
      rem_in  = rem_ff;
      out_in  = out_ff;
      dvd_in  = dvd_ff;
      cnt_in  = cnt_ff;
      if (cmd.load) begin
         base_in = req_base;
         exp_in  = req_exponent;
      end
      if (cmd.mul_start) begin
         dvd_in = DB'(mul_a) * DB'(base_ff);
         rem_in = '0;
         cnt_in = '0;
      end
      if (cmd.rem_step) begin
         rem_in = rem2;
         dvd_in = dvd_ff << 2;
         cnt_in = cnt_ff + CB'(1);
      end
      if (cmd.wb_base) base_in = rem_ff;
      if (cmd.wb_prod) prod_in = rem_ff;
      if (cmd.seed)    prod_in = base_ff;
      if (cmd.set_one) prod_in = WB'(1);
      if (cmd.shift)   exp_in  = exp_ff >> 1;
      if (cmd.out_load) out_in = prod_ff;
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      exp_ff  <= exp_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      out_ff  <= out_in;
      dvd_ff  <= dvd_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign status.exp_zero = (exp_ff == '0);
   assign status.exp_lsb  = exp_ff[0];
   assign status.rem_done = (cnt_ff == CB'(mexp_pkg::STEP_COUNT - 1));
   assign power_result    = out_ff;

endmodule
`default_nettype wire

// ----- design/modular_exponentiation_top.sv -----
// a zero exponent yields a result of one with no multiply; otherwise each modular
// multiply is a product, a remainder pass of two dividend bits per step and a write-back; one square per exponent
// bit below the top set bit plus one multiply per set bit above the lowest, at most 62
// one request at a time, the next taken in the cycle after the result is loaded; a held
// result stalls it
// reset is synchronous: sequencer idle, no result held, modulus back to 2
`default_nettype none
module modular_exponentiation_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [2*mexp_pkg::FIELD_BITS-1:0]    req_tdata,  // exponent (upper half), base (lower half)
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic      [mexp_pkg::FIELD_BITS-1:0]      rsp_tdata,  // power_result
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [mexp_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [mexp_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic      [mexp_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                      csr_pready
);

   localparam int WB = mexp_pkg::WORD_BITS;
   localparam int FB = mexp_pkg::FIELD_BITS;

   mexp_pkg::dp_cmd_type    cmd;
   mexp_pkg::dp_status_type status;
   logic [WB-1:0]           modulus_ff, modulus_in;
   logic [WB-1:0]           wr_value;
   logic [WB-1:0]           power_result;
   logic                    reg_hit;

   assign csr_pready = 1'b1;
   assign reg_hit    = (csr_paddr == mexp_pkg::REG_MODULUS_ADDR);
   assign wr_value   = csr_pwdata[WB-1:0];
   assign csr_prdata = reg_hit ? mexp_pkg::CSR_DATA_BITS'(modulus_ff) : '0;

   always_comb begin
      modulus_in = modulus_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && reg_hit &&
          (wr_value >= mexp_pkg::MODULUS_MIN)) begin
         modulus_in = wr_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= mexp_pkg::MODULUS_RESET;
      end else begin
         modulus_ff <= modulus_in;
      end
   end

   mexp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mexp_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_base     (req_tdata[WB-1:0]),
      .req_exponent (req_tdata[FB+WB-1:FB]),
      .modulus      (modulus_ff),
      .power_result (power_result)
   );

   assign rsp_tdata = FB'(power_result);

endmodule
`default_nettype wire

// ----- design/mexp_checker.sv -----
// port-level assertions for the modular exponentiation block and their binding
`default_nettype none
module mexp_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_tvalid,
   input wire logic                                 req_tready,
   input wire logic [2*mexp_pkg::FIELD_BITS-1:0]    req_tdata,
   input wire logic                                 rsp_tvalid,
   input wire logic                                 rsp_tready,
   input wire logic [mexp_pkg::FIELD_BITS-1:0]      rsp_tdata,
   input wire logic                                 csr_psel,
   input wire logic                                 csr_penable,
   input wire logic                                 csr_pwrite,
   input wire logic [mexp_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input wire logic [mexp_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   input wire logic [mexp_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   input wire logic                                 csr_pready
);

   logic unused_ok;
   assign unused_ok = ^{req_tdata, csr_penable, csr_pwrite, csr_pwdata, csr_pready};

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // busy right after a request is taken
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous still in work");

   // a new result only appears from a request in work
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result without request in work");

   // modulus never reads back below two
   a_modulus_min: assert property (@(posedge clock) disable iff (reset)
      csr_psel && (csr_paddr == mexp_pkg::REG_MODULUS_ADDR) |->
         csr_prdata >= mexp_pkg::CSR_DATA_BITS'(mexp_pkg::MODULUS_MIN))
      else $error("modulus below two");

endmodule

bind modular_exponentiation_top mexp_checker u_mexp_checker (.*);
`default_nettype wire
